// ----- hdl/dreq_pkg.sv -----
package dreq_pkg;

    // Fixed field widths of the request and response transactions
    localparam int CMD_FIELD_W    = 2;
    localparam int UNIT_FIELD_W   = 1;
    localparam int SLOT_FIELD_W   = 6;
    localparam int TRACK_FIELD_W  = 8;
    localparam int STATUS_FIELD_W = 2;

    // Default configuration
    localparam int DEFAULT_ENTRIES     = 64;
    localparam int DEFAULT_UNITS       = 2;
    localparam int DEFAULT_TRACK_WIDTH = 8;

    // Restoring steps needed to reduce a slot-field value by any modulus
    localparam int MOD_STEPS = SLOT_FIELD_W;

    // Command codes; the unused code behaves as a peek
    localparam logic [CMD_FIELD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_FIELD_W-1:0] CMD_PEEK   = 2'd1;
    localparam logic [CMD_FIELD_W-1:0] CMD_RETIRE = 2'd2;

    // Response status codes
    localparam logic [STATUS_FIELD_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_FIELD_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_FIELD_W-1:0] STATUS_DUP   = 2'd2;

    // Slot RAM read address source
    typedef enum logic [1:0] {
        RD_SLOT,
        RD_HEAD,
        RD_PNEXT,
        RD_RDNEXT
    } rd_sel_t;

    // Slot RAM write kind
    typedef enum logic [2:0] {
        WR_NONE,
        WR_NEW,
        WR_LINK_S,
        WR_LINK_P,
        WR_RETIRE
    } wr_sel_t;

    // Response source
    typedef enum logic [1:0] {
        RES_EMPTY,
        RES_DUP,
        RES_INS,
        RES_HEAD
    } res_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     in_ready;
        logic     rd_en;
        rd_sel_t  rd_sel;
        wr_sel_t  wr_sel;
        logic     load_p;
        logic     advance;
        logic     cnt_clear;
        logic     out_load;
        res_sel_t res_sel;
    } dreq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_fire;
        logic is_insert;
        logic is_retire;
        logic slot_queued;
        logic head_valid;
        logic h_le_t;
        logic p_has_next;
        logic rd_has_next;
        logic cond_up;
        logic cond_skip;
        logic cond_fit;
        logic cnt_full;
        logic cnt_last;
        logic out_free;
    } dreq_stat_t;

    // value modulo modulus for values below modulus << MOD_STEPS
    function automatic logic [31:0] mod_reduce(input logic [31:0] value,
                                               input logic [31:0] modulus);
        logic [31:0] rem;
        rem = value;
        for (int k = MOD_STEPS - 1; k >= 0; k--)
        begin
            if (rem >= (modulus << k))
            begin
                rem = rem - (modulus << k);
            end
        end
        return rem;
    endfunction

endpackage

// ----- hdl/dreq_if.sv -----
interface dreq_req_if import dreq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_FIELD_W-1:0]   command;
    logic [UNIT_FIELD_W-1:0]  disk_unit;
    logic [SLOT_FIELD_W-1:0]  request_slot;
    logic [TRACK_FIELD_W-1:0] track;

    modport source (output valid, command, disk_unit, request_slot, track, input ready);
    modport sink   (input valid, command, disk_unit, request_slot, track, output ready);
endinterface

interface dreq_rsp_if import dreq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_FIELD_W-1:0] status;
    logic [SLOT_FIELD_W-1:0]   slot_out;
    logic [TRACK_FIELD_W-1:0]  track_out;
    logic                      queue_nonempty;

    modport source (output valid, status, slot_out, track_out, queue_nonempty, input ready);
    modport sink   (input valid, status, slot_out, track_out, queue_nonempty, output ready);
endinterface

// ----- hdl/dreq_ram.sv -----
module dreq_ram import dreq_pkg::*; #(
    parameter int WIDTH = TRACK_FIELD_W,
    parameter int DEPTH = DEFAULT_ENTRIES
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/dreq_ctrl.sv -----
module dreq_ctrl import dreq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  dreq_stat_t stat,
    output dreq_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_HEAD,
        ST_STEP,
        ST_CHECK,
        ST_LINK_S,
        ST_LINK_P,
        ST_FINISH
    } state_t;

    // up: ascending run above head; skip: pass the upper run; fit: place in wrapped run
    typedef enum logic [1:0] {
        PH_UP,
        PH_SKIP,
        PH_FIT
    } phase_t;

    state_t   state_reg, state_next;
    phase_t   phase_reg, phase_next;
    res_sel_t res_sel_reg, res_sel_next;
    logic     walk_cond;
    logic     end_walk;

    always_comb
    begin
        if (phase_reg == PH_UP)
        begin
            walk_cond = stat.cond_up;
        end
        else if (phase_reg == PH_SKIP)
        begin
            walk_cond = stat.cond_skip;
        end
        else
        begin
            walk_cond = stat.cond_fit;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        res_sel_next  = res_sel_reg;
        end_walk      = 1'b0;
        cmd.in_ready  = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.rd_sel    = RD_SLOT;
        cmd.wr_sel    = WR_NONE;
        cmd.load_p    = 1'b0;
        cmd.advance   = 1'b0;
        cmd.cnt_clear = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.res_sel   = res_sel_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_fire)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.is_insert)
                begin
                    if (stat.slot_queued)
                    begin
                        cmd.rd_en    = 1'b1;
                        cmd.rd_sel   = RD_SLOT;
                        res_sel_next = RES_DUP;
                        state_next   = ST_FINISH;
                    end
                    else if (!stat.head_valid)
                    begin
                        cmd.wr_sel   = WR_NEW;
                        res_sel_next = RES_INS;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_HEAD;
                        state_next = ST_HEAD;
                    end
                end
                else if (!stat.head_valid)
                begin
                    res_sel_next = RES_EMPTY;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = RD_HEAD;
                    res_sel_next = RES_HEAD;
                    state_next   = ST_FINISH;
                end
            end
            ST_HEAD:
            begin
                cmd.load_p = 1'b1;
                phase_next = stat.h_le_t ? PH_UP : PH_SKIP;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (stat.p_has_next && !stat.cnt_full)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PNEXT;
                    state_next = ST_CHECK;
                end
                else
                begin
                    end_walk = 1'b1;
                end
            end
            ST_CHECK:
            begin
                if (walk_cond)
                begin
                    cmd.advance = 1'b1;
                    if (stat.rd_has_next && !stat.cnt_last)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_RDNEXT;
                    end
                    else
                    begin
                        state_next = ST_STEP;
                    end
                end
                else
                begin
                    end_walk = 1'b1;
                end
            end
            ST_LINK_S:
            begin
                cmd.wr_sel = WR_LINK_S;
                state_next = ST_LINK_P;
            end
            ST_LINK_P:
            begin
                cmd.wr_sel   = WR_LINK_P;
                res_sel_next = RES_INS;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (res_sel_reg == RES_HEAD && stat.is_retire)
                    begin
                        cmd.wr_sel = WR_RETIRE;
                    end
                    state_next = ST_IDLE;
                end
            end
        endcase

        if (end_walk)
        begin
            if (phase_reg == PH_SKIP)
            begin
                phase_next    = PH_FIT;
                cmd.cnt_clear = 1'b1;
                state_next    = ST_STEP;
            end
            else
            begin
                state_next = ST_LINK_S;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_UP;
            res_sel_reg <= RES_EMPTY;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            res_sel_reg <= res_sel_next;
        end
    end

    // the compare state always works on data fetched in the cycle before
    a_check_has_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> $past(cmd.rd_en))
        else $error("walk compare without a fresh slot read");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.in_fire |=> state_reg == ST_DISPATCH)
        else $error("accepted transaction not dispatched");

endmodule

// ----- hdl/dreq_dp.sv -----
module dreq_dp import dreq_pkg::*; #(
    parameter int ENTRIES     = DEFAULT_ENTRIES,
    parameter int UNITS       = DEFAULT_UNITS,
    parameter int TRACK_WIDTH = DEFAULT_TRACK_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    dreq_req_if.sink   req,
    dreq_rsp_if.source rsp,
    input  dreq_cmd_t  cmd,
    output dreq_stat_t stat
);

    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int UNIT_W = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int WORD_W = 1 + SLOT_W + TRACK_WIDTH;

    // latched transaction
    logic [CMD_FIELD_W-1:0]  opcode_reg;
    logic [UNIT_W-1:0]       unit_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [TRACK_WIDTH-1:0]  track_reg;

    // queue heads and membership
    logic [SLOT_W-1:0]       head_slot_reg [UNITS];
    logic [UNITS-1:0]        head_valid_reg;
    logic [ENTRIES-1:0]      queued_reg;

    // walk pointer, its slot word, head track, step count
    logic [SLOT_W-1:0]       p_reg;
    logic [WORD_W-1:0]       pw_reg;
    logic [TRACK_WIDTH-1:0]  h_reg;
    logic [CNT_W-1:0]        count_reg;

    // response register
    logic                      out_valid_reg;
    logic [STATUS_FIELD_W-1:0] out_status_reg;
    logic [SLOT_FIELD_W-1:0]   out_slot_reg;
    logic [TRACK_FIELD_W-1:0]  out_track_reg;
    logic                      out_nonempty_reg;

    logic                    in_fire;
    logic [SLOT_W-1:0]       head_slot;
    logic                    head_valid;

    logic                    ram_re;
    logic [SLOT_W-1:0]       ram_raddr;
    logic [WORD_W-1:0]       ram_rdata;
    logic                    ram_we;
    logic [SLOT_W-1:0]       ram_waddr;
    logic [WORD_W-1:0]       ram_wdata;

    logic [TRACK_WIDTH-1:0]  rd_track;
    logic [SLOT_W-1:0]       rd_next;
    logic                    rd_has;
    logic [TRACK_WIDTH-1:0]  pw_track;
    logic [SLOT_W-1:0]       pw_next;
    logic                    pw_has;

    assign in_fire    = req.valid && cmd.in_ready;
    assign req.ready  = cmd.in_ready;
    assign head_slot  = head_slot_reg[unit_reg];
    assign head_valid = head_valid_reg[unit_reg];

    // slot word: {has_next, next, track}
    assign rd_track = ram_rdata[TRACK_WIDTH-1:0];
    assign rd_next  = ram_rdata[TRACK_WIDTH +: SLOT_W];
    assign rd_has   = ram_rdata[WORD_W-1];
    assign pw_track = pw_reg[TRACK_WIDTH-1:0];
    assign pw_next  = pw_reg[TRACK_WIDTH +: SLOT_W];
    assign pw_has   = pw_reg[WORD_W-1];

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            opcode_reg <= req.command;
            unit_reg   <= UNIT_W'(mod_reduce(32'(req.disk_unit), 32'(UNITS)));
            slot_reg   <= SLOT_W'(mod_reduce(32'(req.request_slot), 32'(ENTRIES)));
            track_reg  <= TRACK_WIDTH'(req.track);
        end
    end

    always_comb
    begin
        ram_re = cmd.rd_en;
        unique case (cmd.rd_sel)
            RD_SLOT:   ram_raddr = slot_reg;
            RD_HEAD:   ram_raddr = head_slot;
            RD_PNEXT:  ram_raddr = pw_next;
            RD_RDNEXT: ram_raddr = rd_next;
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b1;
        ram_waddr = slot_reg;
        ram_wdata = {1'b0, SLOT_W'(0), track_reg};
        unique case (cmd.wr_sel)
            WR_NEW:
            begin
                ram_waddr = slot_reg;
                ram_wdata = {1'b0, SLOT_W'(0), track_reg};
            end
            WR_LINK_S:
            begin
                ram_waddr = slot_reg;
                ram_wdata = {pw_has, pw_next, track_reg};
            end
            WR_LINK_P:
            begin
                ram_waddr = p_reg;
                ram_wdata = {1'b1, slot_reg, pw_track};
            end
            WR_RETIRE:
            begin
                ram_waddr = head_slot;
                ram_wdata = {1'b0, rd_next, rd_track};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    dreq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // head slots carry no reset; validity comes from head_valid_reg
    always_ff @(posedge clk)
    begin
        if (cmd.wr_sel == WR_NEW)
        begin
            head_slot_reg[unit_reg] <= slot_reg;
        end
        else if (cmd.wr_sel == WR_RETIRE && rd_has)
        begin
            head_slot_reg[unit_reg] <= rd_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= '0;
            queued_reg     <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.wr_sel == WR_NEW)
            begin
                head_valid_reg[unit_reg] <= 1'b1;
                queued_reg[slot_reg]     <= 1'b1;
            end
            else if (cmd.wr_sel == WR_LINK_S)
            begin
                queued_reg[slot_reg] <= 1'b1;
            end
            else if (cmd.wr_sel == WR_RETIRE)
            begin
                queued_reg[head_slot] <= 1'b0;
                if (!rd_has)
                begin
                    head_valid_reg[unit_reg] <= 1'b0;
                end
            end

            if (cmd.load_p || cmd.cnt_clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.advance)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_p)
        begin
            p_reg  <= head_slot;
            pw_reg <= ram_rdata;
            h_reg  <= rd_track;
        end
        else if (cmd.advance)
        begin
            p_reg  <= pw_next;
            pw_reg <= ram_rdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            unique case (cmd.res_sel)
                RES_EMPTY:
                begin
                    out_status_reg   <= STATUS_EMPTY;
                    out_slot_reg     <= '0;
                    out_track_reg    <= '0;
                    out_nonempty_reg <= 1'b0;
                end
                RES_DUP:
                begin
                    out_status_reg   <= STATUS_DUP;
                    out_slot_reg     <= SLOT_FIELD_W'(slot_reg);
                    out_track_reg    <= TRACK_FIELD_W'(rd_track);
                    out_nonempty_reg <= head_valid;
                end
                RES_INS:
                begin
                    out_status_reg   <= STATUS_OK;
                    out_slot_reg     <= SLOT_FIELD_W'(slot_reg);
                    out_track_reg    <= TRACK_FIELD_W'(track_reg);
                    out_nonempty_reg <= 1'b1;
                end
                RES_HEAD:
                begin
                    out_status_reg   <= STATUS_OK;
                    out_slot_reg     <= SLOT_FIELD_W'(head_slot);
                    out_track_reg    <= TRACK_FIELD_W'(rd_track);
                    out_nonempty_reg <= (opcode_reg == CMD_RETIRE) ? rd_has : 1'b1;
                end
            endcase
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.slot_out       = out_slot_reg;
    assign rsp.track_out      = out_track_reg;
    assign rsp.queue_nonempty = out_nonempty_reg;

    always_comb
    begin
        stat.in_fire     = in_fire;
        stat.is_insert   = (opcode_reg == CMD_INSERT);
        stat.is_retire   = (opcode_reg == CMD_RETIRE);
        stat.slot_queued = queued_reg[slot_reg];
        stat.head_valid  = head_valid;
        stat.h_le_t      = (rd_track <= track_reg);
        stat.p_has_next  = pw_has;
        stat.rd_has_next = rd_has;
        stat.cond_up     = (track_reg >= rd_track) && (rd_track >= h_reg);
        stat.cond_skip   = (h_reg <= rd_track);
        stat.cond_fit    = (track_reg >= rd_track);
        stat.cnt_full    = (count_reg == CNT_W'(ENTRIES));
        stat.cnt_last    = (count_reg == CNT_W'(ENTRIES - 1));
        stat.out_free    = !out_valid_reg || rsp.ready;
    end

    a_link_fresh_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_sel == WR_NEW || cmd.wr_sel == WR_LINK_S) |-> !queued_reg[slot_reg])
        else $error("slot linked while already queued");

    a_retire_queued_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_sel == WR_RETIRE |-> head_valid && queued_reg[head_slot])
        else $error("retire of a head that is not queued");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("queue walk ran past the table size");

endmodule

// ----- hdl/disk_request_elevator_queue_top.sv -----
// C-SCAN disk request queue. Each disk unit owns a singly linked queue of pending requests;
// the links and tracks live in one slot RAM shared by all units, indexed by request slot.
// A request at or above the head's track joins the ascending run after the head, a lower
// one joins the wrapped ascending run after it, and equal tracks keep arrival order; the
// head is never displaced by an insert. One request transaction gives exactly one response
// transaction. Peek, retire, a duplicate insert and an insert into an empty queue need no walk
// before the response register. An insert into a non-empty queue walks its queue, first
// passing the upper run when the new track is below the head's track, then placing it.
// The walk speed is set by the single read port of the slot RAM, one linked entry per
// cycle. One request is worked at a time; a new request is taken while the previous
// response still waits to be taken.
module disk_request_elevator_queue_top import dreq_pkg::*; #(
    parameter int ENTRIES     = DEFAULT_ENTRIES,
    parameter int UNITS       = DEFAULT_UNITS,
    parameter int TRACK_WIDTH = DEFAULT_TRACK_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    dreq_req_if.sink   req,
    dreq_rsp_if.source rsp
);

    // controller drives the datapath only through these two bundles
    dreq_cmd_t  cmd;
    dreq_stat_t stat;

    dreq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // datapath: slot RAM, head registers, queued bits, walk pointer, response register
    dreq_dp #(
        .ENTRIES     (ENTRIES),
        .UNITS       (UNITS),
        .TRACK_WIDTH (TRACK_WIDTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

// ----- test/disk_request_elevator_queue_top_tb.sv -----
`timescale 1ns / 1ps

module disk_request_elevator_queue_top_tb;
    import dreq_pkg::*;

    localparam int N_SLOTS     = DEFAULT_ENTRIES;
    localparam int N_UNITS     = DEFAULT_UNITS;
    localparam int N_ITEMS     = 650;
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int TAIL_CYCLES = 100;   // longer than a full-table walk
    localparam logic [CMD_FIELD_W-1:0] CMD_SPARE = 2'd3;   // unused code, acts as peek

    // One request transaction as queued for the driver. drain holds it back until
    // every earlier response has been taken.
    typedef struct packed {
        logic [CMD_FIELD_W-1:0]   cmd;
        logic [UNIT_FIELD_W-1:0]  unit;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [TRACK_FIELD_W-1:0] trk;
        logic                     drain;
    } disk_req_t;

    // One response transaction
    typedef struct packed {
        logic [STATUS_FIELD_W-1:0] status;
        logic [SLOT_FIELD_W-1:0]   slot;
        logic [TRACK_FIELD_W-1:0]  trk;
        logic                      nonempty;
    } disk_rsp_t;

    logic clk;
    logic rst_n;

    dreq_req_if req_if();
    dreq_rsp_if rsp_if();

    disk_request_elevator_queue_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the scheduler state: per-unit queue heads and the
    // shared slot table with its links.
    // ------------------------------------------------------------------
    logic [SLOT_FIELD_W-1:0]  q_head    [N_UNITS];
    logic                     q_live    [N_UNITS];
    logic [TRACK_FIELD_W-1:0] slot_trk  [N_SLOTS];
    logic [SLOT_FIELD_W-1:0]  slot_nxt  [N_SLOTS];
    logic                     slot_link [N_SLOTS];
    logic                     slot_busy [N_SLOTS];

    disk_req_t request_fifo[$];   // stimulus not yet offered
    disk_rsp_t due_rsp[$];        // responses owed by the block, oldest first

    int n_acc   = 0;   // request transactions accepted (driver only, NBA)
    int n_recv  = 0;   // response transactions taken (monitor only, NBA)
    int n_bad   = 0;
    int n_ins   = 0;
    int n_peek  = 0;
    int n_ret   = 0;
    int n_dup   = 0;
    int n_empty = 0;
    int max_depth = 0;

    int req_gap  = 0;
    int rsp_gap  = 0;
    int hold_cnt = 0;
    logic hold_done = 1'b0;

    // window with no idling on either side
    logic calm;
    assign calm = (n_recv >= 450) && (n_recv < 520);

    // C-SCAN placement: the new slot goes after the last entry of the run it
    // belongs to; ties stay behind earlier arrivals; the head never moves.
    function automatic disk_rsp_t schedule_request(disk_req_t rq);
        disk_rsp_t                r;
        logic [SLOT_FIELD_W-1:0]  p;
        logic [SLOT_FIELD_W-1:0]  s;
        logic [TRACK_FIELD_W-1:0] h;
        logic [TRACK_FIELD_W-1:0] t;
        int                       n;
        int                       depth;
        r = '0;
        s = rq.slot;
        t = rq.trk;
        if (rq.cmd == CMD_INSERT)
        begin
            r.slot = s;
            if (slot_busy[s])
            begin
                r.status = STATUS_DUP;
                r.trk    = slot_trk[s];
            end
            else
            begin
                r.status     = STATUS_OK;
                r.trk        = t;
                slot_trk[s]  = t;
                slot_busy[s] = 1'b1;
                if (!q_live[rq.unit])
                begin
                    q_head[rq.unit] = s;
                    q_live[rq.unit] = 1'b1;
                    slot_link[s]    = 1'b0;
                    slot_nxt[s]     = '0;
                end
                else
                begin
                    p = q_head[rq.unit];
                    h = slot_trk[p];
                    depth = 0;
                    if (h <= t)
                    begin
                        for (n = 0; n < N_SLOTS && slot_link[p] && t >= slot_trk[slot_nxt[p]]
                             && slot_trk[slot_nxt[p]] >= h; n++)
                        begin
                            p = slot_nxt[p];
                            depth++;
                        end
                    end
                    else
                    begin
                        // pass the upper run, then place within the wrapped run
                        for (n = 0; n < N_SLOTS && slot_link[p] && h <= slot_trk[slot_nxt[p]]; n++)
                        begin
                            p = slot_nxt[p];
                            depth++;
                        end
                        for (n = 0; n < N_SLOTS && slot_link[p] && t >= slot_trk[slot_nxt[p]]; n++)
                        begin
                            p = slot_nxt[p];
                            depth++;
                        end
                    end
                    if (depth > max_depth)
                    begin
                        max_depth = depth;
                    end
                    slot_nxt[s]  = slot_nxt[p];
                    slot_link[s] = slot_link[p];
                    slot_nxt[p]  = s;
                    slot_link[p] = 1'b1;
                end
            end
        end
        else if (!q_live[rq.unit])
        begin
            r.status = STATUS_EMPTY;
        end
        else
        begin
            p        = q_head[rq.unit];
            r.status = STATUS_OK;
            r.slot   = p;
            r.trk    = slot_trk[p];
            if (rq.cmd == CMD_RETIRE)
            begin
                if (slot_link[p])
                begin
                    q_head[rq.unit] = slot_nxt[p];
                end
                else
                begin
                    q_live[rq.unit] = 1'b0;
                end
                slot_link[p] = 1'b0;
                slot_busy[p] = 1'b0;
            end
        end
        r.nonempty = q_live[rq.unit];
        return r;
    endfunction

    // mostly back to back, sometimes short gaps, rarely long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_req(logic [CMD_FIELD_W-1:0] cmd, int unit, int slot, int trk,
                                    logic drain);
        disk_req_t rq;
        rq.cmd   = cmd;
        rq.unit  = UNIT_FIELD_W'(unit);
        rq.slot  = SLOT_FIELD_W'(slot);
        rq.trk   = TRACK_FIELD_W'(trk);
        rq.drain = drain;
        request_fifo.push_back(rq);
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------
    // Request driver. The response is predicted at the acceptance edge from
    // the values on the bus, then the next transaction (or a gap) is set up.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        logic      took;
        int        g;
        disk_req_t rq;
        disk_rsp_t want;
        if (!rst_n)
        begin
            req_if.valid        <= 1'b0;
            req_if.command      <= CMD_INSERT;
            req_if.disk_unit    <= '0;
            req_if.request_slot <= '0;
            req_if.track        <= '0;
            req_gap             <= 0;
        end
        else
        begin
            took = req_if.valid && req_if.ready;
            if (took)
            begin
                rq.cmd   = req_if.command;
                rq.unit  = req_if.disk_unit;
                rq.slot  = req_if.request_slot;
                rq.trk   = req_if.track;
                rq.drain = 1'b0;
                want = schedule_request(rq);
                due_rsp.push_back(want);
                n_acc <= n_acc + 1;
                case (rq.cmd)
                    CMD_INSERT: n_ins++;
                    CMD_RETIRE: n_ret++;
                    default:    n_peek++;
                endcase
                if (want.status == STATUS_DUP)
                begin
                    n_dup++;
                end
                if (want.status == STATUS_EMPTY)
                begin
                    n_empty++;
                end
            end
            if (!(req_if.valid && !took))
            begin
                g = took ? (calm ? 0 : gap_len()) : req_gap;
                if (g != 0)
                begin
                    req_gap      <= g - 1;
                    req_if.valid <= 1'b0;
                end
                else if (request_fifo.size() != 0 &&
                         (!request_fifo[0].drain || n_acc + (took ? 1 : 0) == n_recv))
                begin
                    rq = request_fifo.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.command      <= rq.cmd;
                    req_if.disk_unit    <= rq.unit;
                    req_if.request_slot <= rq.slot;
                    req_if.track        <= rq.trk;
                    req_gap             <= 0;
                end
                else
                begin
                    req_if.valid <= 1'b0;
                    req_gap      <= 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Response ready: random stalls, plus one long hold-off so the block
    // backs up and stalls its request side.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : pace_responses
        int g;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rsp_gap      <= 0;
            hold_cnt     <= 0;
            hold_done    <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt     <= hold_cnt - 1;
            rsp_if.ready <= 1'b0;
        end
        else if (!hold_done && n_recv >= 200)
        begin
            hold_cnt     <= HOLD_CYCLES;
            hold_done    <= 1'b1;
            rsp_if.ready <= 1'b0;
        end
        else if (rsp_gap != 0)
        begin
            rsp_gap      <= rsp_gap - 1;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            g = (calm || $urandom_range(0, 3) != 0) ? 0 : gap_len();
            rsp_gap      <= (g > 0) ? g - 1 : 0;
            rsp_if.ready <= (g == 0);
        end
    end

    // ------------------------------------------------------------------
    // Response monitor: compare against the oldest owed response.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_responses
        disk_rsp_t got;
        disk_rsp_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.status   = rsp_if.status;
            got.slot     = rsp_if.slot_out;
            got.trk      = rsp_if.track_out;
            got.nonempty = rsp_if.queue_nonempty;
            if (due_rsp.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                begin
                    $display("%0t: response %0d not owed: status %0d slot %0d track %0d nonempty %0d",
                             $realtime, n_recv, got.status, got.slot, got.trk, got.nonempty);
                end
            end
            else
            begin
                want = due_rsp.pop_front();
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.trk !== want.trk || got.nonempty !== want.nonempty)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                    begin
                        $display("%0t: response %0d wrong: exp status %0d slot %0d track %0d nonempty %0d",
                                 $realtime, n_recv, want.status, want.slot, want.trk,
                                 want.nonempty);
                        $display("    got status %0d slot %0d track %0d nonempty %0d",
                                 got.status, got.slot, got.trk, got.nonempty);
                    end
                end
            end
            n_recv <= n_recv + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int left;
        int mode;
        int lo;
        int span;
        int r;
        logic [CMD_FIELD_W-1:0] cmd;

        for (int i = 0; i < N_UNITS; i++)
        begin
            q_head[i] = '0;
            q_live[i] = 1'b0;
        end
        for (int i = 0; i < N_SLOTS; i++)
        begin
            slot_trk[i]  = '0;
            slot_nxt[i]  = '0;
            slot_link[i] = 1'b0;
            slot_busy[i] = 1'b0;
        end

        // directed: empty queues, ties, wrap, duplicates, spare command
        add_req(CMD_PEEK,   0, 0,  0,   1'b0);
        add_req(CMD_RETIRE, 1, 0,  0,   1'b0);
        add_req(CMD_SPARE,  0, 0,  0,   1'b0);
        add_req(CMD_INSERT, 0, 0,  100, 1'b0);   // into empty queue
        add_req(CMD_INSERT, 0, 63, 255, 1'b0);
        add_req(CMD_INSERT, 0, 5,  100, 1'b0);   // tie with head
        add_req(CMD_INSERT, 0, 7,  0,   1'b0);   // below head, wraps
        add_req(CMD_INSERT, 0, 9,  50,  1'b0);
        add_req(CMD_INSERT, 0, 11, 0,   1'b0);   // tie in wrapped run
        add_req(CMD_INSERT, 0, 0,  3,   1'b0);   // already queued, same unit
        add_req(CMD_INSERT, 1, 5,  200, 1'b0);   // already queued, other unit
        add_req(CMD_INSERT, 1, 42, 170, 1'b0);
        add_req(CMD_INSERT, 1, 21, 160, 1'b0);
        add_req(CMD_SPARE,  1, 63, 255, 1'b0);
        add_req(CMD_PEEK,   0, 0,  0,   1'b0);
        for (int i = 0; i < 7; i++)
        begin
            add_req(CMD_RETIRE, 0, 0, 0, 1'b0);     // last one hits empty
        end
        for (int i = 0; i < 3; i++)
        begin
            add_req(CMD_RETIRE, 1, 0, 0, 1'b0);
        end

        // random phases: fill, drain or mixed, with full-range or narrow tracks
        left = 0;
        while (request_fifo.size() < N_ITEMS)
        begin
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                span = ($urandom_range(0, 3) == 0) ? 3 : 255;
                lo   = $urandom_range(0, 255 - span);
                left = $urandom_range(20, 60);
            end
            r = $urandom_range(0, 99);
            case (mode)
                0: cmd = (r < 70) ? CMD_INSERT : (r < 80) ? CMD_PEEK :
                         (r < 97) ? CMD_RETIRE : CMD_SPARE;
                1: cmd = (r < 20) ? CMD_INSERT : (r < 30) ? CMD_PEEK :
                         (r < 95) ? CMD_RETIRE : CMD_SPARE;
                default: cmd = (r < 50) ? CMD_INSERT : (r < 65) ? CMD_PEEK :
                               (r < 95) ? CMD_RETIRE : CMD_SPARE;
            endcase
            add_req(cmd, $urandom_range(0, 1), $urandom_range(0, 63),
                    lo + $urandom_range(0, span), request_fifo.size() == 300);
            left--;
        end

        wait (rst_n);
        wait (n_acc == N_ITEMS);
        wait (n_recv >= n_acc);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d transactions: %0d inserts (%0d duplicate), %0d peeks, %0d retires",
                 n_acc, n_ins, n_dup, n_peek, n_ret);
        $display("%0d empty-queue responses, deepest insert walk %0d entries, %0d errors",
                 n_empty, max_depth, n_bad);
        if (n_bad == 0 && due_rsp.size() == 0 && n_recv == n_acc)
        begin
            $display("disk_request_elevator_queue_top: match");
        end
        else
        begin
            $display("disk_request_elevator_queue_top: mismatch");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("timeout after %0d of %0d responses", n_recv, N_ITEMS);
        $display("disk_request_elevator_queue_top: mismatch");
        $finish;
    end

endmodule
